// ----- rtl/nnos_pkg.sv -----
package nnos_pkg;

    localparam int BSZ_W      = 5;
    localparam int RCNT_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int KIND_W     = 2;
    localparam int REQ_W      = 8;
    localparam int NUM_W      = 10;
    // wide enough for the slot count, board size and active count compares
    localparam int CMP_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_COUNT  = 1'b1;

    localparam logic [BSZ_W-1:0]  BOARD_SIZE_RST = 5'd4;
    localparam logic [RCNT_W-1:0] REQ_COUNT_RST  = 8'd1;

    localparam logic [KIND_W-1:0] KIND_POST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REQ_W-1:0]  requester;
        logic [NUM_W-1:0]  number;
    } t_in_req;

    typedef struct packed {
        logic              accepted;
        logic              served;
        logic [REQ_W-1:0]  served_requester;
        logic [NUM_W-1:0]  served_number;
    } t_out_res;

    typedef struct packed {
        logic capture;
        logic do_done;
        logic do_start;
        logic free_step;
        logic scan_init;
        logic scan_step;
        logic apply;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              active_nz;
        logic              slot_free;
        logic              free_last;
        logic              scan_last;
        logic              out_free;
    } t_dp_stat;

endpackage

// ----- rtl/nnos_ctrl.sv -----
module nnos_ctrl
    import nnos_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_DECODE     = 8'b0000_0010,
        ST_FREE_SCAN  = 8'b0000_0100,
        ST_CHECK      = 8'b0000_1000,
        ST_SERVE_SCAN = 8'b0001_0000,
        ST_SERVE_TAIL = 8'b0010_0000,
        ST_APPLY      = 8'b0100_0000,
        ST_FINISH     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.kind)
                    KIND_POST: begin
                        n_state = i_stat.full ? ST_CHECK : ST_FREE_SCAN;
                    end
                    KIND_DONE: begin
                        o_cmd.do_done = 1'b1;
                        n_state       = ST_CHECK;
                    end
                    KIND_START: begin
                        o_cmd.do_start = 1'b1;
                        n_state        = ST_FINISH;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_FREE_SCAN: begin
                o_cmd.free_step = 1'b1;
                if (i_stat.slot_free || i_stat.free_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.active_nz && i_stat.full) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SERVE_SCAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SERVE_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_SERVE_TAIL;
                end
            end
            // let the last slot read come back and be compared
            ST_SERVE_TAIL: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/nnos_dp.sv -----
module nnos_dp
    import nnos_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int NUMBER_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_req               i_in_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_res              o_out_res
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = NUMBER_BITS + 1;
    localparam int DW = NUMBER_BITS + 2;

    logic [BSZ_W-1:0]       r_board_size;
    logic [RCNT_W-1:0]      r_req_count;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [CW-1:0]          r_pending;
    logic [RCNT_W-1:0]      r_active;
    logic [LW-1:0]          r_last;
    logic [KIND_W-1:0]      r_kind;
    logic [REQ_W-1:0]       r_req_id;
    logic [NUMBER_BITS-1:0] r_num;
    logic [IW-1:0]          r_idx;
    logic                   r_p_go;
    logic                   r_p_valid;
    logic [IW-1:0]          r_p_idx;
    logic [NUMBER_BITS-1:0] r_rd_num;
    logic [REQ_W-1:0]       r_rd_req;
    logic                   r_found;
    logic [LW-1:0]          r_best_dist;
    logic [IW-1:0]          r_best_idx;
    logic [NUMBER_BITS-1:0] r_best_num;
    logic [REQ_W-1:0]       r_best_req;
    t_out_res               r_res;
    logic                   r_out_valid;
    t_out_res               r_out;

    logic [NUMBER_BITS-1:0] mem_num [MAX_ENTRIES];
    logic [REQ_W-1:0]       mem_req [MAX_ENTRIES];

    logic [CMP_W-1:0]             w_eff;
    logic [CMP_W-1:0]             w_lim;
    logic                         w_full;
    logic                         w_slot_free;
    logic                         w_mem_we;
    logic [NUMBER_BITS+NUM_W-1:0] w_num_in;
    logic [NUMBER_BITS+NUM_W-1:0] w_num_out;
    logic signed [DW-1:0]         w_diff;
    logic [DW-1:0]                w_abs;
    logic [LW-1:0]                w_dist;
    logic                         w_better;

    always_comb begin
        w_eff = (CMP_W'(r_board_size) < CMP_W'(MAX_ENTRIES)) ?
                CMP_W'(r_board_size) : CMP_W'(MAX_ENTRIES);
        w_lim = (CMP_W'(r_active) < w_eff) ? CMP_W'(r_active) : w_eff;
        w_full = CMP_W'(r_pending) >= w_lim;
    end

    assign w_slot_free = !r_valid[r_idx];
    assign w_mem_we    = i_cmd.free_step && w_slot_free;
    assign w_num_in    = {{NUMBER_BITS{1'b0}}, i_in_req.number};
    assign w_num_out   = {{NUM_W{1'b0}}, r_best_num};

    // distance of the slot read back last cycle from the last served number
    assign w_diff   = $signed({2'b00, r_rd_num}) - $signed({r_last[LW-1], r_last});
    assign w_abs    = w_diff[DW-1] ? DW'(-w_diff) : DW'(w_diff);
    assign w_dist   = w_abs[LW-1:0];
    assign w_better = r_p_go && r_p_valid && (!r_found || (w_dist < r_best_dist));

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.full      = w_full;
        o_stat.active_nz = r_active != '0;
        o_stat.slot_free = w_slot_free;
        o_stat.free_last = (CMP_W'(r_idx) + CMP_W'(1)) == w_eff;
        o_stat.scan_last = r_idx == IW'(MAX_ENTRIES - 1);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_num[r_idx] <= r_num;
            mem_req[r_idx] <= r_req_id;
        end
        r_rd_num <= mem_num[r_idx];
        r_rd_req <= mem_req[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= BOARD_SIZE_RST;
            r_req_count  <= REQ_COUNT_RST;
            r_valid      <= '0;
            r_pending    <= '0;
            r_active     <= '0;
            r_last       <= '1;
            r_kind       <= KIND_POST;
            r_idx        <= '0;
            r_p_go       <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOARD_SIZE: r_board_size <= i_cfg_data[BSZ_W-1:0];
                    CFG_REQ_COUNT:  r_req_count  <= i_cfg_data[RCNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            r_p_go <= i_cmd.scan_step;

            if (i_cmd.capture) begin
                r_kind <= i_in_req.kind;
                r_idx  <= '0;
            end
            if (i_cmd.do_done && (r_active != '0)) begin
                r_active <= r_active - RCNT_W'(1);
            end
            if (i_cmd.do_start) begin
                r_valid   <= '0;
                r_pending <= '0;
                r_active  <= r_req_count;
                r_last    <= '1;
            end
            if (i_cmd.free_step) begin
                if (w_slot_free) begin
                    r_valid[r_idx] <= 1'b1;
                    r_pending      <= r_pending + CW'(1);
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            if (i_cmd.scan_init) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step && (r_idx != IW'(MAX_ENTRIES - 1))) begin
                r_idx <= r_idx + IW'(1);
            end
            if (w_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.apply && r_found) begin
                r_valid[r_best_idx] <= 1'b0;
                r_last              <= {1'b0, r_best_num};
                if (r_pending != '0) begin
                    r_pending <= r_pending - CW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_valid <= r_valid[r_idx];
        r_p_idx   <= r_idx;
        if (i_cmd.capture) begin
            r_req_id <= i_in_req.requester;
            r_num    <= w_num_in[NUMBER_BITS-1:0];
            r_res    <= '0;
        end
        if (i_cmd.free_step && w_slot_free) begin
            r_res.accepted <= 1'b1;
        end
        if (i_cmd.do_done || i_cmd.do_start) begin
            r_res.accepted <= 1'b1;
        end
        if (w_better) begin
            r_best_dist <= w_dist;
            r_best_idx  <= r_p_idx;
            r_best_num  <= r_rd_num;
            r_best_req  <= r_rd_req;
        end
        if (i_cmd.apply && r_found) begin
            r_res.served           <= 1'b1;
            r_res.served_requester <= r_best_req;
            r_res.served_number    <= w_num_out[NUM_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// ----- rtl/nearest_number_order_scheduler_top.sv -----
// Nearest-number request scheduler. Each request (post, requester done, start)
// yields exactly one result. The table is searched one slot per clock through
// a single-port slot memory. A post that finds the table not full first scans
// past the occupied slots for a free one; when the table fills, a serve pass
// scans every slot. The input is taken only between requests, while the
// previous result may still wait at the output register. Configuration writes
// apply at once and are meant for idle.
module nearest_number_order_scheduler_top
    import nnos_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int NUMBER_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_res              o_out_res
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    nnos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    nnos_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

`ifndef SYNTHESIS
    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again while a request is in progress");

    // a result never overwrites one that is still stalled at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result register loaded while holding a stalled result");

    a_unserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.served) |->
            (o_out_res.served_requester == '0 && o_out_res.served_number == '0))
        else $error("served fields nonzero without a serve");

    // a request arrives only while no scan command is active
    a_capture_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |-> !(w_cmd.free_step || w_cmd.scan_step || w_cmd.apply))
        else $error("request captured during a table scan");
`endif

endmodule
